>>> rtl/sample_playback_mixer_echo_assert.svh
// Assertion macros for the sample playback mixer.
`ifndef SAMPLE_PLAYBACK_MIXER_ECHO_ASSERT_SVH
`define SAMPLE_PLAYBACK_MIXER_ECHO_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SPME_ASSERT_IMP(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |-> (b)) else $error("implication check failed");
`define SPME_ASSERT_NXT(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |=> (b)) else $error("next-cycle check failed");
`else
`define SPME_ASSERT_IMP(lbl, a, b)
`define SPME_ASSERT_NXT(lbl, a, b)
`endif
`endif

>>> rtl/spme_pkg.sv
// Shared types, constants and scaling functions of the sample playback mixer.
package spme_pkg;

  localparam int VOICES        = 8;
  localparam int VOICE_W       = 3;
  localparam int SAMPLE_FRAMES = 131072;
  localparam int SF_W          = 17;
  localparam int ECHO_FRAMES   = 65536;
  localparam int EF_W          = 16;
  localparam int UNITY         = 800;
  localparam int SPEED_MAX     = 1600;
  localparam int SPEED_WRAP    = 400;

  // reciprocals for exact floor division by constants
  localparam logic [27:0] REC800    = 28'd171798692;  // 2^37 / 800, x < 2^27
  localparam int          REC800_SH = 37;
  localparam logic [31:0] REC800P   = 32'd2748779070; // 2^41 / 800, x <= 2^31
  localparam int          REC800P_SH = 41;
  localparam logic [28:0] REC1995   = 29'd275566825;  // 2^39 / 1995, x < 2^28
  localparam int          REC1995_SH = 39;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_SET   = 3'd2,
    KIND_TRIG  = 3'd3,
    KIND_STEP  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_ECHO_LEVEL = 2'd0,
    REG_ECHO_DELAY = 2'd1,
    REG_AUTO_RETRIG = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos;
    logic [10:0]        speed;
    logic [11:0]        vol;
    logic [18:0]        gap;
    logic [17:0]        vend;
    logic               stopped;
  } voice_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctl_t;

  localparam voice_t VOICE_RESET = '{pos: 32'sd0, speed: 11'd800, vol: 12'd400,
                                     gap: 19'd0, vend: 18'd0, stopped: 1'b1};

  function automatic logic [16:0] div800(input logic [26:0] x);
    logic [54:0] p;
    p = 55'(x) * 55'(REC800);
    return p[REC800_SH +: 17];
  endfunction

  // signed product -> trunc toward zero /800 -> 16-bit wrap
  function automatic logic [15:0] sc16(input logic signed [28:0] p);
    logic [28:0] mag;
    logic [16:0] q;
    mag = p[28] ? 29'(-p) : 29'(p);
    q = div800(mag[26:0]);
    return p[28] ? 16'(-q) : q[15:0];
  endfunction

endpackage

>>> rtl/spme_cell.sv
// One voice cell of the rotating voice chain.
module spme_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  spme_pkg::cell_ctl_t ctl,
  input  spme_pkg::voice_t  nb_i,
  input  spme_pkg::voice_t  wr_i,
  output spme_pkg::voice_t  q_o
);

  spme_pkg::voice_t rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= spme_pkg::VOICE_RESET;
    end else if (ctl.shift) begin
      rec_r <= nb_i;
    end else if (ctl.wr) begin
      rec_r <= wr_i;
    end
  end

  assign q_o = rec_r;

endmodule

>>> rtl/sample_playback_mixer_echo.sv
// Top level: eight-voice stereo sample player with mixer and feedback echo.
// Input words (in_tvalid/in_tready/in_tdata/in_tuser) carry a kind in tuser:
// tick, sample frame write, voice settings, voice trigger or speed step.
// Only a tick produces an output word: the mixed stereo frame with echo.
// A tick visits each voice in turn: a stopped voice is passed over, a voice
// at its end stops or, with auto retrigger, restarts after a gap, and a
// playing voice is read and mixed; then the echo is added. The voice
// records rotate through a ring of cells past one shared datapath, one voice
// per pass, and the sample memory read is registered. Configuration
// (cfg_we/cfg_index/cfg_data) is to be written while idle, a rule left to the user.
// After reset all voices are stopped and the echo history reads as zero;
// a fill count tracks which history entries were written since reset.
// The output word sits in a register; the next input word is taken while
// it waits. A tick that finishes while the output is still held stalls
// until out_tready takes the earlier word.
module sample_playback_mixer_echo (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // voice, frame_address, left_in, right_in, volume, speed, gap_frames,
  // length_frames, step_value, random_value
  input  logic [135:0] in_tdata,
  // kind
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // left_out, right_out
  output logic [31:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_A, S_B, S_C, S_D, S_E, S_F, S_G, S_RD, S_RW, S_SC, S_EA, S_EB, S_EC
  } state_t;

  state_t state_r;

  // input fields
  logic [2:0]         f_voice;
  logic [16:0]        f_addr;
  logic [15:0]        f_left, f_right;
  logic [11:0]        f_vol;
  logic [10:0]        f_speed;
  logic [18:0]        f_gap;
  logic [17:0]        f_len;
  logic [7:0]         f_step;
  logic [14:0]        f_rnd;

  assign f_voice = in_tdata[2:0];
  assign f_addr  = in_tdata[19:3];
  assign f_left  = in_tdata[35:20];
  assign f_right = in_tdata[51:36];
  assign f_vol   = in_tdata[63:52];
  assign f_speed = in_tdata[74:64];
  assign f_gap   = in_tdata[93:75];
  assign f_len   = in_tdata[111:94];
  assign f_step  = in_tdata[119:112];
  assign f_rnd   = in_tdata[134:120];

  // configuration and global state
  logic [10:0] echo_level_r;
  logic [15:0] echo_delay_r;
  logic        auto_r;
  logic [7:0]  step_r;
  logic [spme_pkg::EF_W-1:0] hp_r;
  logic [spme_pkg::EF_W:0]   fill_r;

  // datapath
  spme_pkg::voice_t   w_r;
  logic [spme_pkg::VOICE_W-1:0] vc_r;
  logic [14:0]        rnd_r;
  logic [22:0]        q_r;
  logic [9:0]         b_r;
  logic [33:0]        t1_r;
  logic [20:0]        bs_r;
  logic signed [35:0] frame_r;
  logic [33:0]        rg_r;
  logic [20:0]        ex_r;
  logic               rd_ok_r;
  logic signed [28:0] pl_r, pr_r;
  logic [15:0]        acc_l_r, acc_r_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;

  // memories
  logic [31:0] smem [spme_pkg::VOICES*spme_pkg::SAMPLE_FRAMES];
  logic [31:0] hist [spme_pkg::ECHO_FRAMES];
  logic [31:0] smp_q_r, hist_q_r;
  logic        hv_r;

  // voice chain
  spme_pkg::voice_t    cell_q [spme_pkg::VOICES];
  spme_pkg::cell_ctl_t cell_ctl [spme_pkg::VOICES];
  spme_pkg::voice_t    head, wb_c, cmd_rec_c, sel_rec;
  logic                shift_c;

  logic               acc_in;
  logic               voice_ok;
  logic [31:0]        ap_c;
  logic [31:0]        rem_c;
  logic [63:0]        pq_c;
  logic [59:0]        pg_c;
  logic [34:0]        fmag_c;
  logic               at_end_c;
  logic [11:0]        sp_c;
  logic [spme_pkg::EF_W-1:0] hidx_c;
  logic [15:0]        sl_c, sr_c;
  logic               out_free;

  assign head     = cell_q[0];
  assign acc_in   = in_tvalid && in_tready;
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign voice_ok = ({1'b0, f_voice} < 4'(spme_pkg::VOICES));
  assign out_free = !out_valid_r || out_tready;

  assign ap_c   = w_r.pos[31] ? 32'(-w_r.pos) : 32'(w_r.pos);
  assign rem_c  = ap_c - 32'(q_r) * 32'(spme_pkg::UNITY);
  assign pq_c   = 64'(head.pos[31] ? 32'(-head.pos) : 32'(head.pos)) * 64'(spme_pkg::REC800P);
  assign pg_c   = 60'(rg_r[33:6]) * 60'(spme_pkg::REC1995);
  assign fmag_c = 35'(t1_r) + 35'(spme_pkg::div800(27'(bs_r)));
  assign at_end_c = frame_r >= $signed({18'd0, w_r.vend});
  assign sp_c   = 12'(w_r.speed) + 12'(step_r);
  assign hidx_c = hp_r - echo_delay_r[spme_pkg::EF_W-1:0];
  assign sl_c   = acc_l_r + spme_pkg::sc16(pl_r);
  assign sr_c   = acc_r_r + spme_pkg::sc16(pr_r);

  // writeback into the tail of the ring
  always_comb begin
    shift_c = 1'b0;
    wb_c    = w_r;
    case (state_r)
      S_A: begin
        if (head.stopped) begin
          shift_c = 1'b1;
          wb_c    = head;
        end
      end
      S_E: begin
        if (at_end_c && !auto_r) begin
          shift_c    = 1'b1;
          wb_c.pos   = 32'sd0;
          wb_c.stopped = 1'b1;
        end
      end
      S_SC: begin
        shift_c = 1'b1;
        if (w_r.pos != 32'sh7fffffff) wb_c.pos = w_r.pos + 32'sd1;
      end
      default: begin
        shift_c = 1'b0;
      end
    endcase
  end

  // command writes to the addressed cell while idle
  assign sel_rec = cell_q[f_voice];
  always_comb begin
    cmd_rec_c = sel_rec;
    if (in_tuser == spme_pkg::KIND_SET) begin
      cmd_rec_c.vol   = f_vol;
      cmd_rec_c.speed = f_speed;
      cmd_rec_c.gap   = f_gap;
      cmd_rec_c.vend  = f_len;
    end else begin
      cmd_rec_c.pos     = 32'sd0;
      cmd_rec_c.stopped = 1'b0;
    end
  end

  for (genvar k = 0; k < spme_pkg::VOICES; k++) begin : g_cell
    spme_pkg::voice_t nb;
    if (k == spme_pkg::VOICES - 1) begin : g_tail
      assign nb = wb_c;
    end else begin : g_mid
      assign nb = cell_q[k+1];
    end
    assign cell_ctl[k].shift = shift_c;
    assign cell_ctl[k].wr = acc_in && voice_ok && (f_voice == spme_pkg::VOICE_W'(k)) &&
                            (in_tuser == spme_pkg::KIND_SET || in_tuser == spme_pkg::KIND_TRIG);
    spme_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (cell_ctl[k]),
      .nb_i (nb),
      .wr_i (cmd_rec_c),
      .q_o  (cell_q[k])
    );
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (acc_in && in_tuser == spme_pkg::KIND_WRITE && voice_ok) begin
      smem[{f_voice, f_addr}] <= {f_right, f_left};
    end
    smp_q_r <= smem[{vc_r, frame_r[spme_pkg::SF_W-1:0]}];
  end

  // echo history
  always_ff @(posedge clk) begin
    if (state_r == S_EC && out_free) begin
      hist[hp_r] <= {sr_c, sl_c};
    end
    hist_q_r <= hist[hidx_c];
    hv_r     <= fill_r[spme_pkg::EF_W] || ({1'b0, hidx_c} < fill_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vc_r         <= '0;
      echo_level_r <= 11'd0;
      echo_delay_r <= 16'd22050;
      auto_r       <= 1'b1;
      step_r       <= 8'd0;
      hp_r         <= '0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_EC) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          spme_pkg::REG_ECHO_LEVEL:  echo_level_r <= cfg_data[10:0];
          spme_pkg::REG_ECHO_DELAY:  echo_delay_r <= cfg_data;
          spme_pkg::REG_AUTO_RETRIG: auto_r       <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (acc_in) begin
            case (in_tuser)
              spme_pkg::KIND_TICK: begin
                rnd_r   <= f_rnd;
                acc_l_r <= 16'd0;
                acc_r_r <= 16'd0;
                vc_r    <= '0;
                state_r <= S_A;
              end
              spme_pkg::KIND_TRIG: begin
                if (voice_ok) step_r <= 8'd0;
              end
              spme_pkg::KIND_STEP: step_r <= f_step;
              default: ;
            endcase
          end
        end
        S_A: begin
          w_r <= head;
          q_r <= pq_c[spme_pkg::REC800P_SH +: 23];
          if (head.stopped) begin
            vc_r    <= vc_r + 1'b1;
            state_r <= (vc_r == spme_pkg::VOICE_W'(spme_pkg::VOICES - 1)) ? S_EA : S_A;
          end else begin
            state_r <= S_B;
          end
        end
        S_B: begin
          b_r     <= rem_c[9:0];
          t1_r    <= 34'(q_r) * 34'(w_r.speed);
          state_r <= S_C;
        end
        S_C: begin
          bs_r    <= 21'(b_r) * 21'(w_r.speed);
          state_r <= S_D;
        end
        S_D: begin
          frame_r <= w_r.pos[31] ? -$signed({1'b0, fmag_c}) : $signed({1'b0, fmag_c});
          state_r <= S_E;
        end
        S_E: begin
          if (at_end_c) begin
            if (auto_r) begin
              rg_r    <= 34'(rnd_r) * 34'(w_r.gap);
              state_r <= S_F;
            end else begin
              vc_r    <= vc_r + 1'b1;
              state_r <= (vc_r == spme_pkg::VOICE_W'(spme_pkg::VOICES - 1)) ? S_EA : S_A;
            end
          end else begin
            state_r <= S_RD;
          end
        end
        S_F: begin
          ex_r    <= pg_c[spme_pkg::REC1995_SH +: 21];
          state_r <= S_G;
        end
        S_G: begin
          w_r.pos   <= -$signed(32'(w_r.gap) + 32'(ex_r));
          w_r.speed <= (sp_c > 12'(spme_pkg::SPEED_MAX)) ? 11'(spme_pkg::SPEED_WRAP)
                                                          : sp_c[10:0];
          frame_r   <= 36'sd0;
          state_r   <= S_RD;
        end
        S_RD: begin
          rd_ok_r <= !w_r.pos[31] && (frame_r < $signed(36'(spme_pkg::SAMPLE_FRAMES)));
          state_r <= S_RW;
        end
        S_RW: begin
          pl_r    <= $signed({1'b0, w_r.vol}) * $signed(smp_q_r[15:0]);
          pr_r    <= $signed({1'b0, w_r.vol}) * $signed(smp_q_r[31:16]);
          state_r <= S_SC;
        end
        S_SC: begin
          if (rd_ok_r) begin
            acc_l_r <= sl_c;
            acc_r_r <= sr_c;
          end
          vc_r    <= vc_r + 1'b1;
          state_r <= (vc_r == spme_pkg::VOICE_W'(spme_pkg::VOICES - 1)) ? S_EA : S_A;
        end
        S_EA: begin
          state_r <= S_EB;
        end
        S_EB: begin
          pl_r    <= $signed({2'b0, echo_level_r}) * $signed(hv_r ? hist_q_r[15:0] : 16'd0);
          pr_r    <= $signed({2'b0, echo_level_r}) * $signed(hv_r ? hist_q_r[31:16] : 16'd0);
          state_r <= S_EC;
        end
        S_EC: begin
          if (out_free) begin
            out_data_r  <= {sr_c, sl_c};
            out_valid_r <= 1'b1;
            hp_r        <= hp_r + 1'b1;
            if (!fill_r[spme_pkg::EF_W]) fill_r <= fill_r + 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`include "sample_playback_mixer_echo_assert.svh"

  `SPME_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= (spme_pkg::EF_W+1)'(spme_pkg::ECHO_FRAMES))
  `SPME_ASSERT_IMP(a_no_rotate_idle, in_tready, !shift_c)
  `SPME_ASSERT_NXT(a_out_drain, out_tvalid && out_tready && state_r != S_EC, !out_tvalid)

endmodule
